// File: design/plist_pkg.sv
// Shared types and constants for the positional list engine.
`default_nettype none
package plist_pkg;

  // Default list capacity
  localparam int DefDepth = 16;

  // Fixed field widths
  localparam int ValueW  = 32;
  localparam int PosW    = 5;
  localparam int CntOutW = 5;
  localparam int ReqW    = 3;
  localparam int StatW   = 2;

  typedef enum logic [ReqW-1:0] {
    REQ_INS_FIRST = 3'd0,
    REQ_INS_LAST  = 3'd1,
    REQ_INS_AT    = 3'd2,
    REQ_DEL_FIRST = 3'd3,
    REQ_DEL_LAST  = 3'd4,
    REQ_DEL_AT    = 3'd5,
    REQ_READ_OUT  = 3'd6
  } req_e;

  typedef enum logic [StatW-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BOUNDS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;   // request transfer this cycle
    logic step;     // emit one read-out entry and rotate
  } plist_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic rd_go;    // accepted request starts a non-empty read-out
    logic run_last; // current read-out step is the final one
  } plist_sts_t;

endpackage
`default_nettype wire

// File: design/plist_ctrl.sv
// Controller state machine: request acceptance and read-out sequencing.
`default_nettype none
module plist_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire plist_pkg::plist_sts_t sts_i,
  output plist_pkg::plist_cmd_t    cmd_o,
  output logic                     busy_o
);
  import plist_pkg::*;

  state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    cmd_o.accept = 1'b0;
    cmd_o.step   = 1'b0;
    busy_o       = 1'b0;
    case (state_q)
      S_IDLE: begin
        cmd_o.accept = start_i;
        if (start_i && sts_i.rd_go) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        busy_o     = 1'b1;
        cmd_o.step = 1'b1;
        if (sts_i.run_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: design/plist_dpath.sv
// Datapath: row of list cells with parallel shift, fill count and result registers.
`default_nettype none
module plist_dpath #(
  parameter int DEPTH = plist_pkg::DefDepth
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire plist_pkg::plist_cmd_t             cmd_i,
  output plist_pkg::plist_sts_t                  sts_o,
  input  wire logic [plist_pkg::ReqW-1:0]        req_type_i,
  input  wire logic signed [plist_pkg::ValueW-1:0] item_value_i,
  input  wire logic [plist_pkg::PosW-1:0]        slot_position_i,
  output logic                                   result_valid_o,
  output logic [plist_pkg::StatW-1:0]            status_o,
  output logic signed [plist_pkg::ValueW-1:0]    entry_value_o,
  output logic [plist_pkg::CntOutW-1:0]          entry_count_o,
  output logic                                   last_of_run_o
);
  import plist_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((CW > PosW) ? CW : PosW) + 1;

  logic signed [ValueW-1:0] cell_q [DEPTH];
  logic signed [ValueW-1:0] cell_d [DEPTH];
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            rem_q, rem_d;

  logic                     res_valid_q, res_valid_d;
  status_e                  res_stat_q, res_stat_d;
  logic signed [ValueW-1:0] res_val_q, res_val_d;
  logic [CW-1:0]            res_cnt_q, res_cnt_d;
  logic                     res_last_q, res_last_d;

  req_e          req;
  logic [PW-1:0] pos_ext, cnt_ext, idx;
  logic          do_ins, do_del, list_full, list_empty;
  status_e       op_stat;
  logic          op_result;
  logic [PW-1:0] res_cnt_ext;

  assign req        = req_e'(req_type_i);
  assign pos_ext    = PW'(slot_position_i);
  assign cnt_ext    = PW'(count_q);
  assign list_full  = (count_q == CW'(DEPTH));
  assign list_empty = (count_q == '0);

  // Decode request: checks, target index and status
  always_comb begin
    do_ins    = 1'b0;
    do_del    = 1'b0;
    idx       = '0;
    op_stat   = ST_OK;
    op_result = 1'b1;
    case (req)
      REQ_INS_FIRST, REQ_INS_LAST, REQ_INS_AT: begin
        if (list_full) begin
          op_stat = ST_FULL;
        end else if (req == REQ_INS_FIRST) begin
          do_ins = 1'b1;
        end else if (req == REQ_INS_LAST) begin
          do_ins = 1'b1;
          idx    = cnt_ext;
        end else if (pos_ext == '0 || pos_ext > cnt_ext + PW'(1)) begin
          op_stat = ST_BOUNDS;
        end else begin
          do_ins = 1'b1;
          idx    = pos_ext - PW'(1);
        end
      end
      REQ_DEL_FIRST, REQ_DEL_LAST, REQ_DEL_AT: begin
        if (list_empty) begin
          op_stat = ST_EMPTY;
        end else if (req == REQ_DEL_FIRST) begin
          do_del = 1'b1;
        end else if (req == REQ_DEL_LAST) begin
          do_del = 1'b1;
          idx    = cnt_ext - PW'(1);
        end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
          op_stat = ST_BOUNDS;
        end else begin
          do_del = 1'b1;
          idx    = pos_ext - PW'(1);
        end
      end
      REQ_READ_OUT: begin
        op_stat   = ST_EMPTY;
        op_result = list_empty;
      end
      default: begin
        op_result = 1'b0;
      end
    endcase
  end

  // Status toward the controller
  assign sts_o.rd_go    = (req == REQ_READ_OUT) && !list_empty;
  assign sts_o.run_last = (rem_q == CW'(1));

  // Cell next values: shift right on insert, left on delete, rotate on read-out
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int Prv = (i == 0) ? 0 : i - 1;
    localparam int Nxt = (i == DEPTH - 1) ? i : i + 1;
    localparam logic [PW-1:0] Ip = PW'(i);
    logic ins_here, del_here;
    assign ins_here = cmd_i.accept && do_ins;
    assign del_here = cmd_i.accept && do_del;
    assign cell_d[i] =
      ins_here ? ((Ip == idx) ? item_value_i : ((Ip > idx) ? cell_q[Prv] : cell_q[i])) :
      del_here ? ((Ip >= idx) ? cell_q[Nxt] : cell_q[i]) :
      cmd_i.step ? ((Ip == cnt_ext - PW'(1)) ? cell_q[0] :
                    ((Ip < cnt_ext - PW'(1)) ? cell_q[Nxt] : cell_q[i])) :
      cell_q[i];
  end

  // Hold list cells
  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  // Fill count, read-out counter and result next values
  always_comb begin
    count_d     = count_q;
    rem_d       = rem_q;
    res_valid_d = 1'b0;
    res_stat_d  = ST_OK;
    res_val_d   = '0;
    res_cnt_d   = count_q;
    res_last_d  = 1'b1;
    if (cmd_i.accept) begin
      if (do_ins) begin
        count_d = count_q + CW'(1);
      end else if (do_del) begin
        count_d = count_q - CW'(1);
      end
      if (sts_o.rd_go) begin
        rem_d = count_q;
      end
      res_valid_d = op_result;
      res_stat_d  = op_stat;
      res_cnt_d   = count_d;
    end else if (cmd_i.step) begin
      rem_d       = rem_q - CW'(1);
      res_valid_d = 1'b1;
      res_val_d   = cell_q[0];
      res_last_d  = sts_o.run_last;
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rem_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rem_q       <= rem_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    res_stat_q <= res_stat_d;
    res_val_q  <= res_val_d;
    res_cnt_q  <= res_cnt_d;
    res_last_q <= res_last_d;
  end

  assign res_cnt_ext    = PW'(res_cnt_q);
  assign result_valid_o = res_valid_q;
  assign status_o       = res_stat_q;
  assign entry_value_o  = res_val_q;
  assign entry_count_o  = res_cnt_ext[CntOutW-1:0];
  assign last_of_run_o  = res_last_q;

endmodule
`default_nettype wire

// File: design/positional_list_engine_unit.sv
// Top level of the positional list engine: controller plus datapath.
//
// Channel   Direction  Transfer condition       Payload
// request   in         start_i && !busy_o       req_type_i, item_value_i, slot_position_i
// result    out        result_valid_o           status_o, entry_value_o, entry_count_o,
//                                                last_of_run_o
//
// Insert and delete shift the cell row in parallel; the status appears on the
// cycle after the transfer and busy_o stays low.
// A read-out of N entries rotates the cell row once per cycle and emits one
// entry per cycle while busy_o is high; an empty read-out returns one ST_EMPTY result.
// Reset clears the fill count, the controller and the result strobe.
// The receiver cannot stall: every result is shown for exactly one cycle.
`default_nettype none
module positional_list_engine_unit #(
  parameter int DEPTH = plist_pkg::DefDepth
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic [plist_pkg::ReqW-1:0]          req_type_i,
  input  wire logic signed [plist_pkg::ValueW-1:0] item_value_i,
  input  wire logic [plist_pkg::PosW-1:0]          slot_position_i,
  output logic                                     result_valid_o,
  output logic [plist_pkg::StatW-1:0]              status_o,
  output logic signed [plist_pkg::ValueW-1:0]      entry_value_o,
  output logic [plist_pkg::CntOutW-1:0]            entry_count_o,
  output logic                                     last_of_run_o
);
  import plist_pkg::*;

  plist_cmd_t cmd;
  plist_sts_t sts;

  plist_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  plist_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (req_type_i),
    .item_value_i    (item_value_i),
    .slot_position_i (slot_position_i),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .entry_value_o   (entry_value_o),
    .entry_count_o   (entry_count_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule
`default_nettype wire

// File: verif/tb_positional_list_engine_unit.sv
// Self-checking testbench for the positional list engine: directed and random requests.
`timescale 1ns / 1ps
module tb_positional_list_engine_unit;
  import plist_pkg::*;

  localparam int ListDepth = DefDepth;
  localparam int RandomRequests = 260;
  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 20;
  // Request code that the block ignores without a result
  localparam logic [ReqW-1:0] ReqUnused = 3'd7;

  typedef struct {
    logic [ReqW-1:0]          req;
    logic signed [ValueW-1:0] value;
    logic [PosW-1:0]          pos;
  } list_req_t;

  typedef struct {
    status_e                  status;
    logic signed [ValueW-1:0] value;
    logic [CntOutW-1:0]       count;
    logic                     last;
  } list_reply_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start_i = 1'b0;
  logic [ReqW-1:0]            req_type_i = '0;
  logic signed [ValueW-1:0]   item_value_i = '0;
  logic [PosW-1:0]            slot_position_i = '0;
  logic                       busy_o;
  logic                       result_valid_o;
  logic [StatW-1:0]           status_o;
  logic signed [ValueW-1:0]   entry_value_o;
  logic [CntOutW-1:0]         entry_count_o;
  logic                       last_of_run_o;

  // Stimulus backlog and the replies the list owes
  list_req_t   request_backlog[$];
  list_reply_t list_replies_q[$];

  // Shadow copy of the list contents
  logic signed [ValueW-1:0] list_mem[ListDepth];
  int list_len = 0;

  // Length tracker used while building the stimulus
  int gen_len = 0;
  int request_total = 0;
  int accepted_total = 0;
  int backlog_total = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // Idle burst control for the driver
  int idle_left = 0;
  bit idle_on = 1'b1;

  positional_list_engine_unit #(.DEPTH(ListDepth)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .req_type_i      (req_type_i),
    .item_value_i    (item_value_i),
    .slot_position_i (slot_position_i),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .entry_value_o   (entry_value_o),
    .entry_count_o   (entry_count_o),
    .last_of_run_o   (last_of_run_o)
  );

  always #2 clk_i = ~clk_i;

  // Status of an insert or delete against a list of the given length
  function automatic status_e request_status(logic [ReqW-1:0] req, logic [PosW-1:0] pos,
                                             int len);
    status_e st;
    int p;
    st = ST_OK;
    p = int'(pos);
    case (req)
      REQ_INS_FIRST, REQ_INS_LAST: begin
        if (len >= ListDepth) st = ST_FULL;
      end
      REQ_INS_AT: begin
        if (len >= ListDepth) st = ST_FULL;
        else if (p < 1 || p > len + 1) st = ST_BOUNDS;
      end
      REQ_DEL_FIRST, REQ_DEL_LAST: begin
        if (len == 0) st = ST_EMPTY;
      end
      REQ_DEL_AT: begin
        if (len == 0) st = ST_EMPTY;
        else if (p < 1 || p > len) st = ST_BOUNDS;
      end
      default: ;
    endcase
    return st;
  endfunction

  // Update the shadow list for one transfer and queue the replies it owes
  task automatic apply_list_request(input list_req_t r);
    status_e st;
    int idx;
    list_reply_t rep;
    case (r.req)
      REQ_READ_OUT: begin
        if (list_len == 0) begin
          rep = '{ST_EMPTY, '0, '0, 1'b1};
          list_replies_q.push_back(rep);
        end else begin
          for (int i = 0; i < list_len; i++) begin
            rep = '{ST_OK, list_mem[i], list_len[CntOutW-1:0], (i == list_len - 1)};
            list_replies_q.push_back(rep);
          end
        end
      end
      ReqUnused: ;
      default: begin
        st = request_status(r.req, r.pos, list_len);
        if (st == ST_OK) begin
          if (r.req == REQ_INS_FIRST || r.req == REQ_INS_LAST || r.req == REQ_INS_AT) begin
            if (r.req == REQ_INS_FIRST) idx = 0;
            else if (r.req == REQ_INS_LAST) idx = list_len;
            else idx = int'(r.pos) - 1;
            for (int i = list_len; i > idx; i--) list_mem[i] = list_mem[i-1];
            list_mem[idx] = r.value;
            list_len++;
          end else begin
            if (r.req == REQ_DEL_FIRST) idx = 0;
            else if (r.req == REQ_DEL_LAST) idx = list_len - 1;
            else idx = int'(r.pos) - 1;
            for (int i = idx; i < list_len - 1; i++) list_mem[i] = list_mem[i+1];
            list_len--;
          end
        end
        rep = '{st, '0, list_len[CntOutW-1:0], 1'b1};
        list_replies_q.push_back(rep);
      end
    endcase
  endtask

  // Append one request to the backlog and track the list length it leaves
  task automatic queue_request(input logic [ReqW-1:0] req, input logic [ValueW-1:0] val,
                               input logic [PosW-1:0] pos);
    list_req_t r;
    r = '{req, val, pos};
    request_backlog.push_back(r);
    if (req != ReqUnused) request_total++;
    if (req != REQ_READ_OUT && req != ReqUnused &&
        request_status(req, pos, gen_len) == ST_OK) begin
      if (req == REQ_INS_FIRST || req == REQ_INS_LAST || req == REQ_INS_AT) gen_len++;
      else gen_len--;
    end
  endtask

  // Random value with the extremes mixed in
  function automatic logic [ValueW-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Driver: record transfers, then present the next request or idle
  always @(posedge clk_i) begin : drive_requests
    list_req_t nxt;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        nxt = '{req_type_i, item_value_i, slot_position_i};
        apply_list_request(nxt);
        accepted_total++;
      end
      // Hold a request that the block has not taken yet
      if (!(start_i && busy_o)) begin
        if (idle_left > 0) begin
          idle_left--;
          start_i <= 1'b0;
          req_type_i <= ReqW'($urandom);
          item_value_i <= $urandom;
          slot_position_i <= PosW'($urandom);
        end else if (request_backlog.size() > 0) begin
          if (idle_on && request_backlog.size() > 40 && $urandom_range(0, 3) == 0) begin
            idle_left = $urandom_range(0, 4);
            start_i <= 1'b0;
            req_type_i <= ReqW'($urandom);
            item_value_i <= $urandom;
            slot_position_i <= PosW'($urandom);
          end else begin
            nxt = request_backlog.pop_front();
            start_i <= 1'b1;
            req_type_i <= nxt.req;
            item_value_i <= nxt.value;
            slot_position_i <= nxt.pos;
          end
        end else begin
          start_i <= 1'b0;
        end
      end
      // Alternate stretches with and without idling
      if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
    end
  end

  // Monitor: compare each result with the oldest outstanding reply
  always @(posedge clk_i) begin : check_results
    list_reply_t want;
    if (rst_ni && result_valid_o) begin
      if (list_replies_q.size() == 0) begin
        $error("result_valid_o: result with no request outstanding");
        mismatch_count++;
      end else begin
        want = list_replies_q.pop_front();
        if (status_o !== want.status) begin
          $error("status_o: expected %0d, actual %0d", want.status, status_o);
          mismatch_count++;
        end
        if (entry_value_o !== want.value) begin
          $error("entry_value_o: expected %0d, actual %0d", want.value, entry_value_o);
          mismatch_count++;
        end
        if (entry_count_o !== want.count) begin
          $error("entry_count_o: expected %0d, actual %0d", want.count, entry_count_o);
          mismatch_count++;
        end
        if (last_of_run_o !== want.last) begin
          $error("last_of_run_o: expected %0d, actual %0d", want.last, last_of_run_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int mode;
    // Empty list corner cases
    queue_request(REQ_READ_OUT, '0, '0);
    queue_request(REQ_DEL_FIRST, '0, '0);
    queue_request(REQ_DEL_LAST, '0, '0);
    queue_request(REQ_DEL_AT, '0, 5'd0);
    queue_request(REQ_INS_AT, 32'd5, 5'd0);
    queue_request(REQ_INS_AT, 32'd6, 5'd2);
    // Build a short list with the value extremes
    queue_request(REQ_INS_AT, 32'h7fff_ffff, 5'd1);
    queue_request(REQ_INS_FIRST, 32'h8000_0000, 5'd0);
    queue_request(REQ_INS_LAST, 32'hffff_ffff, 5'd31);
    queue_request(REQ_INS_AT, '0, 5'd4);
    queue_request(REQ_INS_AT, 32'd7, 5'd31);
    queue_request(REQ_DEL_AT, '0, 5'd5);
    queue_request(REQ_DEL_AT, '0, 5'd0);
    queue_request(ReqUnused, 32'hffff_ffff, 5'd31);
    queue_request(REQ_READ_OUT, '0, '0);
    // Take it apart again
    queue_request(REQ_DEL_AT, '0, 5'd2);
    queue_request(REQ_DEL_LAST, '0, '0);
    queue_request(REQ_READ_OUT, 32'hffff_ffff, 5'd31);
    queue_request(REQ_DEL_FIRST, '0, '0);
    queue_request(REQ_DEL_AT, '0, 5'd1);
    queue_request(REQ_READ_OUT, '0, '0);

    // Random runs: fill to full, drain to empty, or noise
    while (request_total < RandomRequests) begin
      mode = $urandom_range(0, 9);
      if (mode < 4) begin
        while (gen_len < ListDepth)
          queue_request(ReqW'($urandom_range(0, 2)), rand_value(),
                        PosW'($urandom_range(1, gen_len + 1)));
        repeat ($urandom_range(1, 3))
          queue_request(ReqW'($urandom_range(0, 2)), rand_value(),
                        PosW'($urandom_range(0, 31)));
        queue_request(REQ_READ_OUT, rand_value(), PosW'($urandom_range(0, 31)));
      end else if (mode < 7) begin
        while (gen_len > 0)
          queue_request(ReqW'($urandom_range(3, 5)), rand_value(),
                        PosW'($urandom_range(1, gen_len)));
        repeat ($urandom_range(1, 2))
          queue_request(ReqW'($urandom_range(3, 5)), rand_value(),
                        PosW'($urandom_range(0, 31)));
        queue_request(REQ_READ_OUT, rand_value(), PosW'($urandom_range(0, 31)));
      end else begin
        repeat (12)
          queue_request(ReqW'($urandom_range(0, 7)), rand_value(),
                        PosW'($urandom_range(0, 31)));
      end
    end
    backlog_total = request_backlog.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every request to transfer, then for every reply
    while (accepted_total != backlog_total) @(posedge clk_i);
    while (list_replies_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
